[rtl/gsu_pkg.sv]
// Package for the generalized sigmoid unit: word format, register indexes,
// series and reciprocal constants, and the rounding and saturation helpers.
// No dependencies.
package gsu_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int WORD_BITS    = 32;
  localparam int DIV_BITS     = WORD_BITS + FRAC_BITS;
  localparam int REG_IDX_W    = 3;
  localparam int TAYLOR_TERMS = 13;
  localparam int EXP_Q_SHIFT  = 30 - FRAC_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_OFFSET_A = 3'd0,
    REG_SCALE_B  = 3'd1,
    REG_BIAS_C   = 3'd2,
    REG_GAIN_D   = 3'd3,
    REG_SLOPE_E  = 3'd4,
    REG_SHIFT_F  = 3'd5
  } reg_idx_e;

  localparam word_t WORD_MAX = word_t'((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam word_t WORD_MIN = word_t'(64'd1 << (WORD_BITS - 1));
  localparam word_t ONE_Q    = word_t'(64'd1 << FRAC_BITS);

  // ln(2) in Q30 and floor(2^46 / LN2_Q30) for the quotient estimate
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [17:0] RECIP_LN2 = 18'd94548;
  localparam logic signed [23:0] EXP_LIM = 24'sd4194304;  // 64.0

  // floor(v / n) = (v * TAY_MUL[n]) >> TAY_SHIFT[n] for any v below 2^31
  localparam logic [31:0] TAY_MUL [1:TAYLOR_TERMS] = '{
    32'd2147483648, 32'd2147483648, 32'd2863311531, 32'd2147483648,
    32'd3435973837, 32'd2863311531, 32'd2454267027, 32'd2147483648,
    32'd3817748708, 32'd3435973837, 32'd3123612579, 32'd2863311531,
    32'd2643056798
  };
  localparam int TAY_SHIFT [1:TAYLOR_TERMS] = '{
    31, 32, 33, 33, 34, 34, 34, 34, 35, 35, 35, 35, 35
  };

  typedef struct packed {
    word_t val;
    logic  flag;
  } word_flag_t;

  function automatic logic [WORD_BITS-1:0] mag(input word_t a);
    return a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
  endfunction

  // apply sign to a magnitude, clamp to the word range
  function automatic word_flag_t sign_limit(input logic [63:0] m, input logic neg);
    word_flag_t  res;
    logic [63:0] lim;
    logic [63:0] mm;
    lim      = neg ? (64'd1 << (WORD_BITS - 1)) : ((64'd1 << (WORD_BITS - 1)) - 64'd1);
    res.flag = m > lim;
    mm       = res.flag ? lim : m;
    res.val  = neg ? word_t'(-mm) : word_t'(mm);
    return res;
  endfunction

  // finish a fixed-point product: round magnitude half away from zero
  function automatic word_flag_t mul_fin(input logic [63:0] p, input logic neg);
    logic [63:0] m;
    m = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return sign_limit(m, neg);
  endfunction

  function automatic word_flag_t sat_add(input word_t a, input word_t b);
    word_flag_t            res;
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    res.flag = s[WORD_BITS] != s[WORD_BITS-1];
    if (res.flag) begin
      res.val = s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end else begin
      res.val = s[WORD_BITS-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/generalized_sigmoid_unit.sv]
// Generalized sigmoid unit: value = A + B/(C + D*exp(E*x+F)), slope value*(1-value).
// Fully pipelined; depends on gsu_pkg.
//
//  port group     direction  handshake               payload
//  sample         in         start / busy            sample_x_i
//  result         out        result_valid_o strobe   act_value_o, act_slope_o, saturated_o
//  coefficients   in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One word enters per clock.
// The pipeline is mostly the 48-stage restoring divider and the 13-term exp series
// (two multiplier stages per term).
// Reset clears all valid bits and loads the standard logistic coefficients.
// The result side cannot stall, so busy stays low and no word is ever held.
module generalized_sigmoid_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  gsu_pkg::word_t                       sample_x_i,
  input  logic                                 cfg_we_i,
  input  logic [gsu_pkg::REG_IDX_W-1:0]        cfg_idx_i,
  input  gsu_pkg::word_t                       cfg_wdata_i,
  output logic                                 result_valid_o,
  output gsu_pkg::word_t                       act_value_o,
  output gsu_pkg::word_t                       act_slope_o,
  output logic                                 saturated_o
);
  import gsu_pkg::*;

  localparam int PIPE_DEPTH = 86;

  // ---------------- coefficient registers
  word_t a_q, b_q, c_q, d_q, e_q, f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= ONE_Q;
      c_q <= ONE_Q;
      d_q <= ONE_Q;
      e_q <= word_t'(-ONE_Q);
      f_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OFFSET_A: a_q <= cfg_wdata_i;
        REG_SCALE_B:  b_q <= cfg_wdata_i;
        REG_BIAS_C:   c_q <= cfg_wdata_i;
        REG_GAIN_D:   d_q <= cfg_wdata_i;
        REG_SLOPE_E:  e_q <= cfg_wdata_i;
        REG_SHIFT_F:  f_q <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- s1: E*x
  logic        s1_vld_q;
  logic [63:0] s1_prod_q;
  logic        s1_neg_q;

  // ---------------- s2: t = sat(E*x + F), clamped
  logic               s2_vld_q;
  logic signed [23:0] s2_t_q;
  logic               s2_f_q;
  word_flag_t         s2_mul, s2_sum;
  logic signed [23:0] s2_t;

  // ---------------- s3: k estimate
  logic               s3_vld_q;
  logic signed [23:0] s3_t_q;
  logic signed [7:0]  s3_k_q;
  logic               s3_f_q;
  logic signed [41:0] s3_kprod;

  // ---------------- s4: r estimate
  logic               s4_vld_q;
  logic signed [39:0] s4_r_q;
  logic signed [7:0]  s4_k_q;
  logic               s4_f_q;
  logic signed [37:0] s4_t30;
  logic signed [38:0] s4_kl;

  // ---------------- s5: corrected k, r
  logic               s5_vld_q;
  logic [29:0]        s5_r_q;
  logic signed [7:0]  s5_k_q;
  logic               s5_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start && !busy;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_comb begin
    s2_mul = mul_fin(s1_prod_q, s1_neg_q);
    s2_sum = sat_add(s2_mul.val, f_q);
    if (s2_sum.val > word_t'(EXP_LIM)) begin
      s2_t = EXP_LIM;
    end else if (s2_sum.val < word_t'(-EXP_LIM)) begin
      s2_t = -EXP_LIM;
    end else begin
      s2_t = s2_sum.val[23:0];
    end
  end

  assign s3_kprod = s2_t_q * $signed(RECIP_LN2);
  assign s4_t30   = {s3_t_q, 14'b0};
  assign s4_kl    = s3_k_q * $signed({1'b0, LN2_Q30});

  always_ff @(posedge clk_i) begin
    s1_prod_q <= mag(e_q) * mag(sample_x_i);
    s1_neg_q  <= e_q[WORD_BITS-1] ^ sample_x_i[WORD_BITS-1];

    s2_t_q <= s2_t;
    s2_f_q <= s2_mul.flag | s2_sum.flag;

    s3_t_q <= s2_t_q;
    s3_k_q <= s3_kprod[39:32];
    s3_f_q <= s2_f_q;

    s4_r_q <= {{2{s4_t30[37]}}, s4_t30} - {s4_kl[38], s4_kl};
    s4_k_q <= s3_k_q;
    s4_f_q <= s3_f_q;

    // fix the estimate by one step either way
    if (s4_r_q[39]) begin
      s5_r_q <= 30'(s4_r_q + 40'(LN2_Q30));
      s5_k_q <= s4_k_q - 8'sd1;
    end else if (s4_r_q >= 40'(LN2_Q30)) begin
      s5_r_q <= 30'(s4_r_q - 40'(LN2_Q30));
      s5_k_q <= s4_k_q + 8'sd1;
    end else begin
      s5_r_q <= s4_r_q[29:0];
      s5_k_q <= s4_k_q;
    end
    s5_f_q <= s4_f_q;
  end

  // ---------------- Taylor series of exp(r), two stages per term
  logic [60:0]       ta_p_q   [1:TAYLOR_TERMS];
  logic [32:0]       ta_sum_q [1:TAYLOR_TERMS];
  logic [29:0]       ta_r_q   [1:TAYLOR_TERMS];
  logic signed [7:0] ta_k_q   [1:TAYLOR_TERMS];
  logic              ta_f_q   [1:TAYLOR_TERMS];
  logic              ta_vld_q [1:TAYLOR_TERMS];
  logic [30:0]       tb_term_q[1:TAYLOR_TERMS];
  logic [32:0]       tb_sum_q [1:TAYLOR_TERMS];
  logic [29:0]       tb_r_q   [1:TAYLOR_TERMS];
  logic signed [7:0] tb_k_q   [1:TAYLOR_TERMS];
  logic              tb_f_q   [1:TAYLOR_TERMS];
  logic              tb_vld_q [1:TAYLOR_TERMS];

  for (genvar n = 1; n <= TAYLOR_TERMS; n++) begin : g_tay
    logic [30:0]       term_in;
    logic [32:0]       sum_in;
    logic [29:0]       r_in;
    logic signed [7:0] k_in;
    logic              f_in;
    logic              vld_in;
    logic [62:0]       dprod;

    if (n == 1) begin : g_first
      assign term_in = 31'd1 << 30;
      assign sum_in  = '0;
      assign r_in    = s5_r_q;
      assign k_in    = s5_k_q;
      assign f_in    = s5_f_q;
      assign vld_in  = s5_vld_q;
    end else begin : g_next
      assign term_in = tb_term_q[n-1];
      assign sum_in  = tb_sum_q[n-1];
      assign r_in    = tb_r_q[n-1];
      assign k_in    = tb_k_q[n-1];
      assign f_in    = tb_f_q[n-1];
      assign vld_in  = tb_vld_q[n-1];
    end

    assign dprod = ta_p_q[n][60:30] * TAY_MUL[n];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ta_vld_q[n] <= 1'b0;
        tb_vld_q[n] <= 1'b0;
      end else begin
        ta_vld_q[n] <= vld_in;
        tb_vld_q[n] <= ta_vld_q[n];
      end
    end

    always_ff @(posedge clk_i) begin
      // add the previous term, multiply it by r
      ta_p_q[n]   <= term_in * r_in;
      ta_sum_q[n] <= sum_in + {2'b0, term_in};
      ta_r_q[n]   <= r_in;
      ta_k_q[n]   <= k_in;
      ta_f_q[n]   <= f_in;
      // divide by n through the reciprocal
      tb_term_q[n] <= 31'(dprod >> TAY_SHIFT[n]);
      tb_sum_q[n]  <= ta_sum_q[n];
      tb_r_q[n]    <= ta_r_q[n];
      tb_k_q[n]    <= ta_k_q[n];
      tb_f_q[n]    <= ta_f_q[n];
    end
  end

  // ---------------- exp: scale series by 2^k
  logic               x1_vld_q;
  word_t              x1_e_q;
  logic               x1_f_q;
  logic [32:0]        x1_sum;
  logic signed [8:0]  x1_sh;
  logic [8:0]         x1_shr;
  logic [63:0]        x1_wide;
  word_t              x1_e;
  logic               x1_ovf;

  always_comb begin
    x1_sum  = tb_sum_q[TAYLOR_TERMS] + {2'b0, tb_term_q[TAYLOR_TERMS]};
    x1_sh   = {tb_k_q[TAYLOR_TERMS][7], tb_k_q[TAYLOR_TERMS]} - 9'(EXP_Q_SHIFT);
    x1_shr  = 9'(-x1_sh);
    x1_wide = '0;
    x1_e    = '0;
    x1_ovf  = 1'b0;
    if (!x1_sh[8]) begin
      if (x1_sh > 9'(WORD_BITS - 31)) begin
        x1_ovf = 1'b1;
      end else begin
        x1_wide = {31'b0, x1_sum} << x1_sh;
        x1_ovf  = x1_wide > 64'(WORD_MAX);
      end
      x1_e = x1_ovf ? WORD_MAX : word_t'(x1_wide);
    end else if (x1_shr <= 9'd62) begin
      x1_wide = ({31'b0, x1_sum} + (64'd1 << (x1_shr - 9'd1))) >> x1_shr;
      x1_e    = word_t'(x1_wide);
    end
  end

  // ---------------- denominator: C + D*e
  logic        m2a_vld_q;
  logic [63:0] m2a_prod_q;
  logic        m2a_neg_q;
  logic        m2a_f_q;
  logic        m2b_vld_q;
  word_t       m2b_den_q;
  logic        m2b_f_q;
  word_flag_t  m2b_mul, m2b_sum;

  assign m2b_mul = mul_fin(m2a_prod_q, m2a_neg_q);
  assign m2b_sum = sat_add(c_q, m2b_mul.val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_vld_q  <= 1'b0;
      m2a_vld_q <= 1'b0;
      m2b_vld_q <= 1'b0;
    end else begin
      x1_vld_q  <= tb_vld_q[TAYLOR_TERMS];
      m2a_vld_q <= x1_vld_q;
      m2b_vld_q <= m2a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_e_q     <= x1_e;
    x1_f_q     <= tb_f_q[TAYLOR_TERMS] | x1_ovf;
    m2a_prod_q <= mag(d_q) * WORD_BITS'(x1_e_q);
    m2a_neg_q  <= d_q[WORD_BITS-1];
    m2a_f_q    <= x1_f_q;
    m2b_den_q  <= m2b_sum.val;
    m2b_f_q    <= m2a_f_q | m2b_mul.flag | m2b_sum.flag;
  end

  // ---------------- restoring divider, one quotient bit per stage
  logic [WORD_BITS-1:0] dv_rem_q [0:DIV_BITS-1];
  logic [DIV_BITS-1:0]  dv_num_q [0:DIV_BITS-1];
  logic [WORD_BITS-1:0] dv_ud_q  [0:DIV_BITS-1];
  logic                 dv_neg_q [0:DIV_BITS-1];
  logic                 dv_dz_q  [0:DIV_BITS-1];
  logic                 dv_f_q   [0:DIV_BITS-1];
  logic                 dv_vld_q [0:DIV_BITS-1];

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
    logic [WORD_BITS-1:0] rem_in;
    logic [DIV_BITS-1:0]  num_in;
    logic [WORD_BITS-1:0] ud_in;
    logic                 neg_in;
    logic                 dz_in;
    logic                 f_in;
    logic                 vld_in;
    logic [WORD_BITS:0]   trial;
    logic                 fits;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = {mag(b_q), {FRAC_BITS{1'b0}}};
      assign ud_in  = mag(m2b_den_q);
      assign neg_in = b_q[WORD_BITS-1] ^ m2b_den_q[WORD_BITS-1];
      assign dz_in  = m2b_den_q == '0;
      assign f_in   = m2b_f_q;
      assign vld_in = m2b_vld_q;
    end else begin : g_next
      assign rem_in = dv_rem_q[i-1];
      assign num_in = dv_num_q[i-1];
      assign ud_in  = dv_ud_q[i-1];
      assign neg_in = dv_neg_q[i-1];
      assign dz_in  = dv_dz_q[i-1];
      assign f_in   = dv_f_q[i-1];
      assign vld_in = dv_vld_q[i-1];
    end

    assign trial = {rem_in, num_in[DIV_BITS-1]};
    assign fits  = trial >= {1'b0, ud_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[i] <= 1'b0;
      end else begin
        dv_vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_rem_q[i] <= fits ? WORD_BITS'(trial - {1'b0, ud_in}) : trial[WORD_BITS-1:0];
      dv_num_q[i] <= {num_in[DIV_BITS-2:0], fits};
      dv_ud_q[i]  <= ud_in;
      dv_neg_q[i] <= neg_in;
      dv_dz_q[i]  <= dz_in;
      dv_f_q[i]   <= f_in;
    end
  end

  // ---------------- output stages
  logic                 f1_vld_q;
  word_t                f1_q_q;
  logic                 f1_f_q;
  logic [DIV_BITS:0]    f1_quo;
  word_flag_t           f1_lim;
  word_t                f1_q;
  logic                 f1_f;

  logic                 f2_vld_q;
  word_t                f2_val_q;
  word_t                f2_om_q;
  logic                 f2_f_q;
  word_flag_t           f2_val, f2_om;

  logic                 f3_vld_q;
  logic [63:0]          f3_prod_q;
  logic                 f3_neg_q;
  word_t                f3_val_q;
  logic                 f3_f_q;
  word_flag_t           f4_mul;

  localparam int DL = DIV_BITS - 1;

  always_comb begin
    // round quotient half away from zero
    f1_quo = {1'b0, dv_num_q[DL]} +
             (DIV_BITS+1)'({dv_rem_q[DL], 1'b0} >= {1'b0, dv_ud_q[DL]});
    f1_lim = sign_limit(64'(f1_quo), dv_neg_q[DL]);
    f1_q   = f1_lim.val;
    f1_f   = dv_f_q[DL] | f1_lim.flag;
    if (dv_dz_q[DL]) begin
      f1_f = 1'b1;
      if (b_q > word_t'(0)) begin
        f1_q = WORD_MAX;
      end else if (b_q < word_t'(0)) begin
        f1_q = WORD_MIN;
      end else begin
        f1_q = '0;
      end
    end
  end

  assign f2_val = sat_add(a_q, f1_q_q);
  assign f2_om  = sat_add(ONE_Q, word_t'(-f2_val.val));
  assign f4_mul = mul_fin(f3_prod_q, f3_neg_q);

  // ONE_Q - v: negating the smallest word overflows, handle that case apart
  word_flag_t f2_om_fix;
  always_comb begin
    f2_om_fix = f2_om;
    if (f2_val.val == WORD_MIN) begin
      f2_om_fix.val  = WORD_MAX;
      f2_om_fix.flag = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q       <= 1'b0;
      f2_vld_q       <= 1'b0;
      f3_vld_q       <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      f1_vld_q       <= dv_vld_q[DL];
      f2_vld_q       <= f1_vld_q;
      f3_vld_q       <= f2_vld_q;
      result_valid_o <= f3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q_q <= f1_q;
    f1_f_q <= f1_f;

    f2_val_q <= f2_val.val;
    f2_om_q  <= f2_om_fix.val;
    f2_f_q   <= f1_f_q | f2_val.flag | f2_om_fix.flag;

    f3_prod_q <= mag(f2_val_q) * mag(f2_om_q);
    f3_neg_q  <= f2_val_q[WORD_BITS-1] ^ f2_om_q[WORD_BITS-1];
    f3_val_q  <= f2_val_q;
    f3_f_q    <= f2_f_q;

    act_value_o <= f3_val_q;
    act_slope_o <= f4_mul.val;
    saturated_o <= f3_f_q | f4_mul.flag;
  end

  // ---------------- assertions
  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(s1_vld_q, PIPE_DEPTH - 1))
    else $error("result strobe without a matching sample");

  a_reduced_arg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_vld_q |-> (s5_r_q < LN2_Q30))
    else $error("exp reduced argument out of range");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld_q[DL] && !dv_dz_q[DL]) |-> (dv_rem_q[DL] < dv_ud_q[DL]))
    else $error("divider remainder not below divisor");

endmodule

[sim/testbench.sv]
// Self-checking bench for generalized_sigmoid_unit: a queue-fed driver, a clocked
// monitor and a bit-exact fixed-point predictor of value, slope and saturation flag.
// Depends on gsu_pkg and the generalized_sigmoid_unit RTL.
`timescale 1ns / 1ps

module testbench;
  import gsu_pkg::*;

  localparam longint W_MAX  = 64'sd2147483647;
  localparam longint W_MIN  = -64'sd2147483648;
  localparam longint Q_ONE  = 64'sd65536;
  localparam longint LN2_30 = 64'sd744261118;
  localparam longint X_LIM  = 64'sd64 <<< 16;
  localparam int     DRAIN_CYCLES = 120;

  typedef enum logic [1:0] {CMD_SAMPLE, CMD_WRITE, CMD_IDLE, CMD_DRAIN} cmd_e;
  typedef struct {
    cmd_e     kind;
    reg_idx_e idx;
    word_t    data;
  } cmd_t;
  typedef struct {
    word_t value;
    word_t slope;
    logic  flag;
  } sig_out_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  word_t    sample_x_i = '0;
  logic     cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i = '0;
  word_t    cfg_wdata_i = '0;
  logic     result_valid_o;
  word_t    act_value_o, act_slope_o;
  logic     saturated_o;

  cmd_t     pending_cmds[$];
  sig_out_t expected_outs[$];
  longint   coef[6];
  int       idle_pct = 0;
  int       errors = 0;

  generalized_sigmoid_unit dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------- fixed-point predictor ----------------
  function automatic longint clamp_word(longint v, inout bit flag);
    if (v > W_MAX) begin flag = 1; return W_MAX; end
    if (v < W_MIN) begin flag = 1; return W_MIN; end
    return v;
  endfunction

  function automatic longint apply_sign(longint unsigned m, bit neg, inout bit flag);
    longint unsigned lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (m > lim) begin flag = 1; m = lim; end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fx_mul(longint a, longint b, inout bit flag);
    longint unsigned ua, ub, p;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p  = ua * ub;
    return apply_sign((p + 64'd32768) >> 16, (a < 0) != (b < 0), flag);
  endfunction

  function automatic longint fx_exp(longint t, inout bit flag);
    longint t30, k, r, s;
    longint unsigned term, sum, v;
    if (t > X_LIM) t = X_LIM;
    if (t < -X_LIM) t = -X_LIM;
    t30 = t * 16384;
    k = t30 / LN2_30;
    r = t30 - k * LN2_30;
    if (r < 0) begin k--; r += LN2_30; end
    term = 64'd1 << 30;
    sum  = term;
    for (int n = 1; n <= 13; n++) begin
      term = ((term * longint'(r)) >> 30) / n;
      sum += term;
    end
    s = k - 14;
    if (s >= 0) begin
      if (s > 1) begin flag = 1; return W_MAX; end
      v = sum << s;
      if (v > 64'd2147483647) begin flag = 1; return W_MAX; end
      return longint'(v);
    end
    s = -s;
    if (s > 62) return 0;
    return longint'((sum + (64'd1 << (s - 1))) >> s);
  endfunction

  function automatic longint fx_div(longint b, longint d, inout bit flag);
    longint unsigned ud, num, q, rem;
    ud  = d < 0 ? -d : d;
    num = (b < 0 ? -b : b) << 16;
    q   = num / ud;
    rem = num % ud;
    if (2 * rem >= ud) q++;
    return apply_sign(q, (b < 0) != (d < 0), flag);
  endfunction

  function automatic sig_out_t predict_sigmoid(word_t x_in);
    sig_out_t o;
    bit       flag;
    longint   t, ex, den, q, v, om;
    flag = 0;
    t   = clamp_word(fx_mul(coef[REG_SLOPE_E], longint'(x_in), flag) + coef[REG_SHIFT_F], flag);
    ex  = fx_exp(t, flag);
    den = clamp_word(coef[REG_BIAS_C] + fx_mul(coef[REG_GAIN_D], ex, flag), flag);
    if (den == 0) begin
      flag = 1;
      q = coef[REG_SCALE_B] > 0 ? W_MAX : (coef[REG_SCALE_B] < 0 ? W_MIN : 0);
    end else begin
      q = fx_div(coef[REG_SCALE_B], den, flag);
    end
    v  = clamp_word(coef[REG_OFFSET_A] + q, flag);
    om = clamp_word(Q_ONE - v, flag);
    o.slope = word_t'(fx_mul(v, om, flag));
    o.value = word_t'(v);
    o.flag  = flag;
    return o;
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_start, nxt_we;
    if (!rst_ni) begin
      start    <= 1'b0;
      cfg_we_i <= 1'b0;
      coef = '{0, Q_ONE, Q_ONE, Q_ONE, -Q_ONE, 0};
    end else begin
      nxt_start = 1'b0;
      nxt_we    = 1'b0;
      if (start && !busy) expected_outs.push_back(predict_sigmoid(sample_x_i));
      if (start && busy) begin
        nxt_start = 1'b1;  // hold until taken
      end else if (pending_cmds.size() > 0) begin
        case (pending_cmds[0].kind)
          CMD_SAMPLE: begin
            if ($urandom_range(99) >= idle_pct) begin
              nxt_start = 1'b1;
              sample_x_i <= pending_cmds[0].data;
              void'(pending_cmds.pop_front());
            end
          end
          CMD_WRITE: begin
            if (expected_outs.size() == 0 && !start) begin
              nxt_we = 1'b1;
              cfg_idx_i   <= pending_cmds[0].idx;
              cfg_wdata_i <= pending_cmds[0].data;
              coef[pending_cmds[0].idx] = longint'(pending_cmds[0].data);
              void'(pending_cmds.pop_front());
            end
          end
          CMD_IDLE: begin
            idle_pct = pending_cmds[0].data;
            void'(pending_cmds.pop_front());
          end
          CMD_DRAIN: begin
            if (expected_outs.size() == 0 && !start) void'(pending_cmds.pop_front());
          end
        endcase
      end
      start    <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    sig_out_t exp_o;
    if (rst_ni && result_valid_o) begin
      if (expected_outs.size() == 0) begin
        $display("%0t: unexpected word value=%h slope=%h flag=%b",
                 $time, act_value_o, act_slope_o, saturated_o);
        errors++;
      end else begin
        exp_o = expected_outs.pop_front();
        if (act_value_o !== exp_o.value) begin
          $display("%0t: act_value expected %h actual %h", $time, exp_o.value, act_value_o);
          errors++;
        end
        if (act_slope_o !== exp_o.slope) begin
          $display("%0t: act_slope expected %h actual %h", $time, exp_o.slope, act_slope_o);
          errors++;
        end
        if (saturated_o !== exp_o.flag) begin
          $display("%0t: saturated expected %b actual %b", $time, exp_o.flag, saturated_o);
          errors++;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic add_sample(word_t x);
    pending_cmds.push_back('{CMD_SAMPLE, REG_OFFSET_A, x});
  endtask

  task automatic add_write(reg_idx_e idx, word_t val);
    pending_cmds.push_back('{CMD_WRITE, idx, val});
  endtask

  task automatic add_ctrl(cmd_e kind, int val);
    pending_cmds.push_back('{kind, REG_OFFSET_A, word_t'(val)});
  endtask

  // mostly arguments in the interesting +-16.0 band, some over the full range
  task automatic add_random_samples(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) add_sample(word_t'($urandom));
      else add_sample(word_t'(int'($urandom_range(2097152)) - 1048576));
    end
  endtask

  task automatic load_coefs(word_t a, word_t b, word_t c, word_t d, word_t e, word_t f);
    add_write(REG_OFFSET_A, a);
    add_write(REG_SCALE_B, b);
    add_write(REG_BIAS_C, c);
    add_write(REG_GAIN_D, d);
    add_write(REG_SLOPE_E, e);
    add_write(REG_SHIFT_F, f);
  endtask

  initial begin
    word_t edge_x[] = '{32'sh0, 32'sh7fffffff, 32'sh80000000, 32'sh10000, -32'sh10000,
                        32'sh400000, -32'sh400000, 32'sh3ffffff, -32'sh3ffffff,
                        32'sh1, -32'sh1, 32'sh8000};
    // directed: extremes under reset coefficients, exp clamp and overflow
    foreach (edge_x[i]) add_sample(edge_x[i]);
    // zero divisor with positive, negative and zero numerator
    load_coefs(0, ONE_Q, 0, 0, -ONE_Q, 0);
    add_sample(32'sh1234);
    add_write(REG_SCALE_B, -32'sh30000);
    add_sample(-32'sh1234);
    add_write(REG_SCALE_B, 0);
    add_sample(0);
    // coefficient extremes
    load_coefs(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    add_sample(32'sh7fffffff);
    add_sample(-32'sh10000);
    load_coefs(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    add_sample(32'sh80000000);
    add_sample(32'sh10000);
    // standard logistic again, random over idling phases
    load_coefs(0, ONE_Q, ONE_Q, ONE_Q, -ONE_Q, 0);
    add_random_samples(250);
    add_ctrl(CMD_IDLE, 62);
    add_random_samples(250);
    add_ctrl(CMD_DRAIN, 0);
    add_random_samples(50);
    // random coefficient sets, small gains so the curve stays in range
    for (int s = 0; s < 6; s++) begin
      add_ctrl(CMD_IDLE, (s % 3 == 0) ? 0 : ((s % 3 == 1) ? 62 : 13));
      load_coefs(word_t'(int'($urandom_range(262144)) - 131072),
                 word_t'(int'($urandom_range(262144)) - 131072),
                 word_t'(int'($urandom_range(131072)) - 65536),
                 word_t'($urandom_range(200000)),
                 word_t'(int'($urandom_range(262144)) - 131072),
                 word_t'(int'($urandom_range(262144)) - 131072));
      add_random_samples(120);
    end
    add_ctrl(CMD_IDLE, 13);
    load_coefs(word_t'($urandom), word_t'($urandom), word_t'($urandom),
               word_t'($urandom), word_t'($urandom), word_t'($urandom));
    add_random_samples(100);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_cmds.size() != 0 || start || expected_outs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_outs.size() == 0) begin
      $display("[generalized_sigmoid_unit] OK");
    end else begin
      $display("[generalized_sigmoid_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[generalized_sigmoid_unit] ERROR");
    $finish;
  end

endmodule
